>>> sv/tmm_pkg.sv
// ----------------------------------------------------------------------------
// tmm_pkg: shared types and helpers of the trackball motion mode mapper
// Item and result layouts, mode codes, tap codes and accumulator arithmetic.
// ----------------------------------------------------------------------------
package tmm_pkg;

    localparam int unsigned ThWidth  = 10;
    localparam int unsigned AccWidth = 16;
    localparam int unsigned MaxRes   = 3;

    typedef enum logic [3:0] {
        MODE_MOUSE = 4'd0,
        MODE_WINSW = 4'd1,
        MODE_SCRL  = 4'd2,
        MODE_SCRLV = 4'd3,
        MODE_SCRLH = 4'd4,
        MODE_CRT   = 4'd5,
        MODE_CRTV  = 4'd6,
        MODE_CRTH  = 4'd7,
        MODE_WINMV = 4'd8
    } mode_t;

    typedef enum logic [2:0] {
        KEY_WINSW = 3'd0,
        KEY_SCRL  = 3'd1,
        KEY_SCRLV = 3'd2,
        KEY_SCRLH = 3'd3,
        KEY_CRT   = 3'd4,
        KEY_CRTV  = 3'd5,
        KEY_CRTH  = 3'd6,
        KEY_WINMV = 3'd7
    } key_t;

    typedef enum logic [1:0] {
        KIND_REPORT   = 2'd0,
        KIND_TAP      = 2'd1,
        KIND_MODIFIER = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        TAP_TAB       = 3'd0,
        TAP_SHIFT_TAB = 3'd1,
        TAP_RIGHT     = 3'd2,
        TAP_LEFT      = 3'd3,
        TAP_DOWN      = 3'd4,
        TAP_UP        = 3'd5
    } tap_t;

    localparam logic MOD_ALT = 1'b0;
    localparam logic MOD_GUI = 1'b1;

    localparam logic ACT_MOTION = 1'b0;
    localparam logic ACT_KEY    = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_WINSW_TH = 2'd0;
    localparam logic [1:0] REG_SCRL_TH  = 2'd1;
    localparam logic [1:0] REG_CRT_TH   = 2'd2;
    localparam logic [1:0] REG_WINMV_TH = 2'd3;

    typedef struct packed {
        logic [ThWidth-1:0] winsw_th;
        logic [ThWidth-1:0] scrl_th;
        logic [ThWidth-1:0] crt_th;
        logic [ThWidth-1:0] winmv_th;
    } cfg_t;

    typedef struct packed {
        logic              action;
        key_t              mode_key;
        logic              pressed;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] wheel_vert_in;
        logic signed [7:0] wheel_horz_in;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic signed [7:0] out_x;
        logic signed [7:0] out_y;
        logic signed [7:0] wheel_vert_out;
        logic signed [7:0] wheel_horz_out;
        tap_t              tap_code;
        logic              modifier_id;
        logic              modifier_down;
        logic              last;
    } res_t;

    // Results of one item, handed from the mapping logic to the output buffer
    typedef struct packed {
        logic                  load;
        logic [1:0]            cnt;
        res_t [MaxRes-1:0]     slot;
    } load_t;

    // Saturating add of an 8-bit motion delta into a 16-bit accumulator
    function automatic logic signed [AccWidth-1:0] sat_add(
        input logic signed [AccWidth-1:0] acc,
        input logic signed [7:0]          d
    );
        logic signed [AccWidth:0] s;
        s = {acc[AccWidth-1], acc} + {{(AccWidth-7){d[7]}}, d};
        if (s[AccWidth] != s[AccWidth-1]) begin
            sat_add = s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}}
                                  : {1'b0, {(AccWidth-1){1'b1}}};
        end else begin
            sat_add = s[AccWidth-1:0];
        end
    endfunction

    // Magnitude strictly above threshold
    function automatic logic over_th(
        input logic signed [AccWidth-1:0] acc,
        input logic [ThWidth-1:0]         th
    );
        logic [AccWidth:0] mag;
        mag = acc[AccWidth-1] ? (~{acc[AccWidth-1], acc} + 1'b1)
                              : {acc[AccWidth-1], acc};
        over_th = mag > {{(AccWidth+1-ThWidth){1'b0}}, th};
    endfunction

    function automatic res_t mk_tap(input tap_t code);
        res_t r;
        r          = '0;
        r.kind     = KIND_TAP;
        r.tap_code = code;
        mk_tap     = r;
    endfunction

endpackage

>>> sv/tmm_cfg.sv
// ----------------------------------------------------------------------------
// tmm_cfg: threshold registers
// APB-style register bank holding the four mode thresholds.
// ----------------------------------------------------------------------------
module tmm_cfg
    import tmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write the addressed threshold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.winsw_th <= ThWidth'(32);
            cfg_reg.scrl_th  <= ThWidth'(16);
            cfg_reg.crt_th   <= ThWidth'(16);
            cfg_reg.winmv_th <= ThWidth'(32);
        end else if (wr_en) begin
            case (reg_idx)
                REG_WINSW_TH: cfg_reg.winsw_th <= pwdata[ThWidth-1:0];
                REG_SCRL_TH:  cfg_reg.scrl_th  <= pwdata[ThWidth-1:0];
                REG_CRT_TH:   cfg_reg.crt_th   <= pwdata[ThWidth-1:0];
                REG_WINMV_TH: cfg_reg.winmv_th <= pwdata[ThWidth-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_WINSW_TH: prdata[ThWidth-1:0] = cfg_reg.winsw_th;
            REG_SCRL_TH:  prdata[ThWidth-1:0] = cfg_reg.scrl_th;
            REG_CRT_TH:   prdata[ThWidth-1:0] = cfg_reg.crt_th;
            REG_WINMV_TH: prdata[ThWidth-1:0] = cfg_reg.winmv_th;
            default:      prdata = '0;
        endcase
    end

endmodule

>>> sv/tmm_core.sv
// ----------------------------------------------------------------------------
// tmm_core: input register, mode state and motion mapping
// Registers one input transfer, applies it to mode and accumulators and
// builds the list of results it causes in a single pass.
// ----------------------------------------------------------------------------
module tmm_core
    import tmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  cfg_t        cfg,
    input  logic        buf_free,
    output load_t       ld
);

    logic                        in_valid_reg;
    item_t                       in_data_reg;
    item_t                       in_word;
    mode_t                       mode_reg, mode_next;
    logic signed [AccWidth-1:0]  acc_x_reg, acc_x_next;
    logic signed [AccWidth-1:0]  acc_y_reg, acc_y_next;
    logic signed [AccWidth-1:0]  sum_x, sum_y;
    logic                        use_x, use_y;
    logic [ThWidth-1:0]          th;
    logic                        fire_x, fire_y;
    logic                        tap_x, tap_y;
    logic                        is_scroll, is_arrow;
    logic                        take;
    res_t                        rep, res_x, res_y;

    // Unpack the input transfer
    assign in_word.action        = s_tuser[0];
    assign in_word.mode_key      = key_t'(s_tdata[2:0]);
    assign in_word.pressed       = s_tdata[3];
    assign in_word.delta_x       = s_tdata[11:4];
    assign in_word.delta_y       = s_tdata[19:12];
    assign in_word.wheel_vert_in = s_tdata[27:20];
    assign in_word.wheel_horz_in = s_tdata[35:28];

    assign take     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    // Hold the input item until the result buffer takes its results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= in_word;
        end
    end

    // Axis use and threshold per mode
    always_comb begin
        use_x     = 1'b0;
        use_y     = 1'b0;
        th        = cfg.scrl_th;
        is_scroll = 1'b0;
        is_arrow  = 1'b0;
        case (mode_reg)
            MODE_WINSW: begin
                use_x = 1'b1;
                th    = cfg.winsw_th;
            end
            MODE_SCRL: begin
                use_x = 1'b1; use_y = 1'b1; is_scroll = 1'b1;
            end
            MODE_SCRLV: begin
                use_y = 1'b1; is_scroll = 1'b1;
            end
            MODE_SCRLH: begin
                use_x = 1'b1; is_scroll = 1'b1;
            end
            MODE_CRT: begin
                use_x = 1'b1; use_y = 1'b1; is_arrow = 1'b1; th = cfg.crt_th;
            end
            MODE_CRTV: begin
                use_y = 1'b1; is_arrow = 1'b1; th = cfg.crt_th;
            end
            MODE_CRTH: begin
                use_x = 1'b1; is_arrow = 1'b1; th = cfg.crt_th;
            end
            MODE_WINMV: begin
                use_x = 1'b1; use_y = 1'b1; is_arrow = 1'b1; th = cfg.winmv_th;
            end
            default: ;
        endcase
    end

    // Accumulate and test against the threshold
    assign sum_x  = use_x ? sat_add(acc_x_reg, in_data_reg.delta_x) : acc_x_reg;
    assign sum_y  = use_y ? sat_add(acc_y_reg, in_data_reg.delta_y) : acc_y_reg;
    assign fire_x = use_x && over_th(sum_x, th);
    assign fire_y = use_y && over_th(sum_y, th);
    assign tap_x  = fire_x && (is_arrow || mode_reg == MODE_WINSW);
    assign tap_y  = fire_y && is_arrow;

    // Tap results and the closing report
    always_comb begin
        if (mode_reg == MODE_WINSW) begin
            res_x = mk_tap(sum_x[AccWidth-1] ? TAP_SHIFT_TAB : TAP_TAB);
        end else begin
            res_x = mk_tap(sum_x[AccWidth-1] ? TAP_LEFT : TAP_RIGHT);
        end
        res_y = mk_tap(sum_y[AccWidth-1] ? TAP_UP : TAP_DOWN);

        rep                = '0;
        rep.kind           = KIND_REPORT;
        rep.last           = 1'b1;
        rep.wheel_vert_out = in_data_reg.wheel_vert_in;
        rep.wheel_horz_out = in_data_reg.wheel_horz_in;
        if (mode_reg == MODE_MOUSE) begin
            rep.out_x = in_data_reg.delta_x;
            rep.out_y = in_data_reg.delta_y;
        end
        if (is_scroll && fire_y) begin
            rep.wheel_vert_out = sum_y[AccWidth-1] ? 8'sd1 : -8'sd1;
        end
        if (is_scroll && fire_x) begin
            rep.wheel_horz_out = sum_x[AccWidth-1] ? -8'sd1 : 8'sd1;
        end
    end

    // Next state and result list
    always_comb begin
        mode_next  = mode_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        ld         = '0;
        ld.load    = take;
        if (in_data_reg.action == ACT_KEY) begin
            if (in_data_reg.pressed) begin
                mode_next = mode_t'({1'b0, in_data_reg.mode_key} + 4'd1);
            end else begin
                mode_next  = MODE_MOUSE;
                acc_x_next = '0;
                acc_y_next = '0;
            end
            if (in_data_reg.mode_key == KEY_WINSW || in_data_reg.mode_key == KEY_WINMV) begin
                ld.cnt                   = 2'd1;
                ld.slot[0].kind          = KIND_MODIFIER;
                ld.slot[0].modifier_id   = (in_data_reg.mode_key == KEY_WINMV) ? MOD_GUI
                                                                               : MOD_ALT;
                ld.slot[0].modifier_down = in_data_reg.pressed;
                ld.slot[0].last          = 1'b1;
            end
        end else begin
            acc_x_next = fire_x ? '0 : sum_x;
            acc_y_next = fire_y ? '0 : sum_y;
            ld.cnt     = 2'd1 + {1'b0, tap_x} + {1'b0, tap_y};
            ld.slot[0] = tap_x ? res_x : (tap_y ? res_y : rep);
            ld.slot[1] = (tap_x && tap_y) ? res_y : rep;
            ld.slot[2] = rep;
        end
    end

    // Commit state when the item's results are loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MOUSE;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (take) begin
            mode_reg  <= mode_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

`ifndef SYNTHESIS
    a_mouse_acc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_MOUSE |-> acc_x_reg == '0 && acc_y_reg == '0)
        else $error("accumulator not clear in mouse mode");

    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_data_reg.action == ACT_KEY && !in_data_reg.pressed
        |=> mode_reg == MODE_MOUSE && acc_x_reg == '0 && acc_y_reg == '0)
        else $error("key release did not return to mouse mode");

    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !buf_free |=> in_valid_reg && $stable(in_data_reg))
        else $error("pending item lost while result buffer busy");
`endif

endmodule

>>> sv/tmm_out.sv
// ----------------------------------------------------------------------------
// tmm_out: result buffer and serialiser
// Holds up to three results of one item and sends them one per transfer.
// ----------------------------------------------------------------------------
module tmm_out
    import tmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  load_t       ld,
    output logic        buf_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    res_t              slot_reg [MaxRes];
    logic [1:0]        cnt_reg;
    logic [1:0]        idx_reg;
    logic              take;
    logic              at_end;
    res_t              cur;

    assign m_tvalid = cnt_reg != 2'd0;
    assign take     = m_tvalid && m_tready;
    assign at_end   = idx_reg == (cnt_reg - 2'd1);
    assign buf_free = !m_tvalid || (take && at_end);

    // Advance through the held results, reload when the last one goes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (ld.load) begin
            cnt_reg <= ld.cnt;
            idx_reg <= 2'd0;
        end else if (take) begin
            if (at_end) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.load) begin
            for (int i = 0; i < MaxRes; i++) begin
                slot_reg[i] <= ld.slot[i];
            end
        end
    end

    // Present the current result
    assign cur     = slot_reg[idx_reg];
    assign m_tdata = {3'b000, cur.modifier_down, cur.modifier_id, cur.tap_code,
                      cur.wheel_horz_out, cur.wheel_vert_out, cur.out_y, cur.out_x};
    assign m_tuser = cur.kind;
    assign m_tlast = cur.last;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> idx_reg < cnt_reg)
        else $error("result index beyond held count");

    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == at_end)
        else $error("last flag does not match final held result");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ld.load && ld.cnt != 2'd0 |=> m_tvalid && idx_reg == 2'd0)
        else $error("loaded results not presented");
`endif

endmodule

>>> sv/trackball_motion_mode_mapper_unit.sv
// ----------------------------------------------------------------------------
// trackball_motion_mode_mapper_unit: trackball mode mapper top level
// Maps trackball motion to pointer, wheel, key-tap and modifier results.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): motion reports (s_tuser 0) and mode-key events
//   (s_tuser 1). Output stream (m_*): mouse reports, key taps and modifier
//   changes, kind in m_tuser; m_tlast marks the final result of each item.
//   A mode-key event of the scroll or caret keys gives no result.
//   Thresholds are set through the APB port at byte addresses 0, 4, 8, 12.
// Timing:
//   The first result of an item passes the input register, then the result
//   buffer, before it can transfer. The mapping logic between them is
//   combinational, and an item occupies the output until all its results (up
//   to three) have transferred; with single-result items and no stall one
//   item is taken every cycle. The three-entry result buffer sets this.
// Reset:
//   aresetn low returns to mouse mode, clears both accumulators, restores
//   the default thresholds and empties both stages.
// Stall:
//   While m_tready is low the current result holds, the input register
//   fills and then s_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module trackball_motion_mode_mapper_unit
    import tmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode_key[2:0], pressed[3], delta_x[11:4],
                                   // delta_y[19:12], wheel_vert_in[27:20],
                                   // wheel_horz_in[35:28], zero pad[39:36]
    input  logic [0:0]  s_tuser,   // action[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_x[7:0], out_y[15:8],
                                   // wheel_vert_out[23:16], wheel_horz_out[31:24],
                                   // tap_code[34:32], modifier_id[35],
                                   // modifier_down[36], zero pad[39:37]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    load_t ld;
    logic  buf_free;

    tmm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmm_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .buf_free (buf_free),
        .ld       (ld)
    );

    tmm_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (ld),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/tmm_result_checker.sv
// ----------------------------------------------------------------------------
// tmm_result_checker: result checker for the trackball motion mode mapper
// Watches the input, result and register ports. Keeps its own copy of the
// mode, accumulators and thresholds, works out the results of each input
// transfer and compares each result transfer, field by field, with the
// oldest result still due.
// ----------------------------------------------------------------------------
module tmm_result_checker
    import tmm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          results_due
);

    mode_t              cur_mode;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic [9:0]         th_winsw;
    logic [9:0]         th_scrl;
    logic [9:0]         th_crt;
    logic [9:0]         th_winmv;
    res_t               due_results[$];

    // Add a motion delta, clamped to the 16-bit signed range
    function automatic logic signed [15:0] acc_add(input logic signed [15:0] a,
                                                   input logic signed [7:0]  d);
        int s;
        s = int'(a) + int'(d);
        if (s > 32767) begin
            s = 32767;
        end else if (s < -32768) begin
            s = -32768;
        end
        return s[15:0];
    endfunction

    // Magnitude strictly above the threshold
    function automatic logic exceeds(input logic signed [15:0] a, input logic [9:0] th);
        int mag;
        mag = (a < 0) ? -int'(a) : int'(a);
        return mag > int'(th);
    endfunction

    task automatic push_tap(input tap_t code);
        res_t r;
        r          = '0;
        r.kind     = KIND_TAP;
        r.tap_code = code;
        due_results.push_back(r);
    endtask

    // Work out the results of one input transfer and advance the mode state
    task automatic map_item(input item_t it);
        res_t               r;
        logic               ux;
        logic               uy;
        logic signed [7:0]  wv;
        logic signed [7:0]  wh;
        logic [9:0]         th;
        r = '0;
        if (it.action == ACT_KEY) begin
            if (it.pressed) begin
                cur_mode = mode_t'({1'b0, it.mode_key} + 4'd1);
            end else begin
                cur_mode = MODE_MOUSE;
                acc_x    = '0;
                acc_y    = '0;
            end
            // window keys hold a modifier while down
            if (it.mode_key == KEY_WINSW || it.mode_key == KEY_WINMV) begin
                r.kind          = KIND_MODIFIER;
                r.modifier_id   = (it.mode_key == KEY_WINMV) ? MOD_GUI : MOD_ALT;
                r.modifier_down = it.pressed;
                r.last          = 1'b1;
                due_results.push_back(r);
            end
        end else begin
            ux = cur_mode inside {MODE_WINSW, MODE_SCRL, MODE_SCRLH, MODE_CRT,
                                  MODE_CRTH, MODE_WINMV};
            uy = cur_mode inside {MODE_SCRL, MODE_SCRLV, MODE_CRT, MODE_CRTV,
                                  MODE_WINMV};
            if (ux) acc_x = acc_add(acc_x, it.delta_x);
            if (uy) acc_y = acc_add(acc_y, it.delta_y);
            wv = it.wheel_vert_in;
            wh = it.wheel_horz_in;
            case (cur_mode)
                MODE_WINSW: begin
                    if (exceeds(acc_x, th_winsw)) begin
                        push_tap((acc_x > 0) ? TAP_TAB : TAP_SHIFT_TAB);
                        acc_x = '0;
                    end
                end
                MODE_SCRL, MODE_SCRLV, MODE_SCRLH: begin
                    // wheel step replaces the incoming wheel value
                    if (uy && exceeds(acc_y, th_scrl)) begin
                        wv    = (acc_y > 0) ? -8'sd1 : 8'sd1;
                        acc_y = '0;
                    end
                    if (ux && exceeds(acc_x, th_scrl)) begin
                        wh    = (acc_x > 0) ? 8'sd1 : -8'sd1;
                        acc_x = '0;
                    end
                end
                MODE_CRT, MODE_CRTV, MODE_CRTH, MODE_WINMV: begin
                    th = (cur_mode == MODE_WINMV) ? th_winmv : th_crt;
                    if (ux && exceeds(acc_x, th)) begin
                        push_tap((acc_x > 0) ? TAP_RIGHT : TAP_LEFT);
                        acc_x = '0;
                    end
                    if (uy && exceeds(acc_y, th)) begin
                        push_tap((acc_y > 0) ? TAP_DOWN : TAP_UP);
                        acc_y = '0;
                    end
                end
                default: ;
            endcase
            // report always closes the item; pointer motion only in mouse mode
            r.kind = KIND_REPORT;
            if (cur_mode == MODE_MOUSE) begin
                r.out_x = it.delta_x;
                r.out_y = it.delta_y;
            end
            r.wheel_vert_out = wv;
            r.wheel_horz_out = wh;
            r.last           = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        item_t it;
        res_t  want;
        if (!aresetn) begin
            cur_mode    = MODE_MOUSE;
            acc_x       = '0;
            acc_y       = '0;
            th_winsw    = 10'd32;
            th_scrl     = 10'd16;
            th_crt      = 10'd16;
            th_winmv    = 10'd32;
            error_count = 0;
            due_results.delete();
        end else begin
            // track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WINSW_TH: th_winsw = pwdata[9:0];
                    REG_SCRL_TH:  th_scrl  = pwdata[9:0];
                    REG_CRT_TH:   th_crt   = pwdata[9:0];
                    REG_WINMV_TH: th_winmv = pwdata[9:0];
                    default: ;
                endcase
            end
            // predict on each input transfer
            if (s_tvalid && s_tready) begin
                it               = '0;
                it.action        = s_tuser[0];
                it.mode_key      = key_t'(s_tdata[2:0]);
                it.pressed       = s_tdata[3];
                it.delta_x       = s_tdata[11:4];
                it.delta_y       = s_tdata[19:12];
                it.wheel_vert_in = s_tdata[27:20];
                it.wheel_horz_in = s_tdata[35:28];
                map_item(it);
            end
            // compare each result transfer with the oldest result due
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing due: tuser %0d tdata %h",
                           m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("out_x", want.out_x, $signed(m_tdata[7:0]));
                    check_field("out_y", want.out_y, $signed(m_tdata[15:8]));
                    check_field("wheel_vert_out", want.wheel_vert_out,
                                $signed(m_tdata[23:16]));
                    check_field("wheel_horz_out", want.wheel_horz_out,
                                $signed(m_tdata[31:24]));
                    check_field("tap_code", want.tap_code, m_tdata[34:32]);
                    check_field("modifier_id", want.modifier_id, m_tdata[35]);
                    check_field("modifier_down", want.modifier_down, m_tdata[36]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
        results_due = due_results.size();
    end

endmodule

>>> tb/sv/tb_trackball_motion_mode_mapper_unit.sv
// ----------------------------------------------------------------------------
// tb_trackball_motion_mode_mapper_unit: testbench of the mode mapper
// Drives mode-key events and motion reports through the input stream in
// directed and random phases under several threshold settings, with random
// gaps on both streams and one long result stall. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_trackball_motion_mode_mapper_unit;
    import tmm_pkg::*;

    localparam int QuietLimit = 2000;
    localparam int StallCycles = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          error_count;
    int          results_due;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          stall_req = 1'b0;

    always #6 aclk = ~aclk;

    trackball_motion_mode_mapper_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tmm_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .error_count (error_count),
        .results_due (results_due)
    );

    // Result side: random back-pressure, and one long stall on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                stall_left = StallCycles;
                stall_req  = 1'b0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 23);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one item, with a random gap first, and hold until its transfer
    task automatic send_item(input logic act, input key_t k, input logic prs,
                             input logic [7:0] dx, input logic [7:0] dy,
                             input logic [7:0] wv, input logic [7:0] wh);
        while (idle_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, wh, wv, dy, dx, prs, k};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mode-key event; the motion fields carry junk
    task automatic key_event(input key_t k, input logic prs);
        send_item(ACT_KEY, k, prs, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // Motion report; key fields carry junk
    task automatic motion(input logic [7:0] dx, input logic [7:0] dy,
                          input logic [7:0] wv, input logic [7:0] wh);
        send_item(ACT_MOTION, key_t'($urandom_range(7)), 1'($urandom), dx, dy, wv, wh);
    endtask

    function automatic logic [7:0] rand_delta();
        int v;
        if ($urandom_range(1)) begin
            v = $urandom_range(255);
        end else begin
            v = $urandom_range(80);
            v = v - 40;
        end
        return v[7:0];
    endfunction

    // Register write: setup then access; psel stays up across a burst
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {22'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [9:0] winsw, input logic [9:0] scrl,
                                  input logic [9:0] crt, input logic [9:0] winmv);
        write_reg(REG_WINSW_TH, winsw);
        write_reg(REG_SCRL_TH, scrl);
        write_reg(REG_CRT_TH, crt);
        write_reg(REG_WINMV_TH, winmv);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every due result, then let key events settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Mostly press / motion / release runs, the rest loose items
    task automatic run_random(input int quota);
        int   sent;
        int   n;
        key_t k;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 75) begin
                k = key_t'($urandom_range(7));
                key_event(k, 1'b1);
                n = $urandom_range(8, 1);
                repeat (n) motion(rand_delta(), rand_delta(), 8'($urandom), 8'($urandom));
                if ($urandom_range(9) != 0) begin
                    key_event(k, 1'b0);
                end else begin
                    key_event(key_t'($urandom_range(7)), 1'($urandom));
                end
                sent += n + 2;
            end else begin
                send_item(1'($urandom), key_t'($urandom_range(7)), 1'($urandom),
                          rand_delta(), rand_delta(), 8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pass-through extremes, then every mode and key
        motion(8'sd127, -8'sd128, 8'sd127, -8'sd128);
        motion(-8'sd128, 8'sd127, -8'sd128, 8'sd127);
        key_event(KEY_WINSW, 1'b1);
        motion(8'sd127, 8'sd90, 8'sd3, -8'sd3);
        motion(-8'sd128, 8'sd0, 8'sd0, 8'sd0);
        key_event(KEY_WINSW, 1'b0);
        key_event(KEY_SCRL, 1'b1);
        motion(8'sd100, -8'sd100, 8'sd7, 8'sd9);
        // switch modes without a release: accumulators carry over
        key_event(KEY_SCRLV, 1'b1);
        motion(8'sd20, 8'sd50, 8'sd0, -8'sd5);
        key_event(KEY_SCRLH, 1'b1);
        motion(-8'sd50, 8'sd30, -8'sd1, 8'sd1);
        key_event(KEY_CRT, 1'b1);
        motion(8'sd127, 8'sd127, 8'sd11, 8'sd12);
        key_event(KEY_CRTV, 1'b1);
        motion(8'sd5, -8'sd127, 8'sd0, 8'sd0);
        key_event(KEY_CRTH, 1'b1);
        motion(-8'sd127, 8'sd3, 8'sd0, 8'sd0);
        key_event(KEY_WINMV, 1'b1);
        motion(-8'sd128, -8'sd128, 8'sd1, 8'sd2);
        key_event(KEY_SCRL, 1'b0);
        key_event(KEY_WINMV, 1'b0);
        // release with no matching press still lifts the modifier
        key_event(KEY_WINSW, 1'b0);
        drain();

        // zero thresholds: any nonzero sum fires
        set_thresholds(10'd0, 10'd0, 10'd0, 10'd0);
        run_random(45);
        drain();

        // top thresholds, with no idling on either side
        idle_on = 1'b0;
        set_thresholds(10'd1023, 10'd1023, 10'd1023, 10'd1023);
        run_random(45);
        drain();
        idle_on = 1'b1;

        set_thresholds(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                       10'($urandom_range(1023)), 10'($urandom_range(1023)));
        run_random(45);
        drain();

        // small thresholds under a long result stall
        set_thresholds(10'($urandom_range(40)), 10'($urandom_range(40)),
                       10'($urandom_range(40)), 10'($urandom_range(40)));
        stall_req = 1'b1;
        run_random(50);
        drain();

        set_thresholds(10'd1023, 10'd0, 10'd5, 10'd1023);
        run_random(45);
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
